FILE: rtl/pnpcc_pkg.sv
// ============================================================================
// pnpcc_pkg
// Shared types, codes and the helper function of the per-node path and cycle
// counter: controller commands, datapath status and the bit search helper.
// ============================================================================
package pnpcc_pkg;

  // Width of the bit search helper; rows are zero-extended to it.
  localparam int unsigned SEARCH_W = 64;

  // Configuration register indexes.
  localparam logic REG_NODE_TOTAL = 1'b0;
  localparam logic REG_SYMMETRIC  = 1'b1;

  // Request kinds carried on the input tuser bit.
  localparam logic MODE_EDGE  = 1'b0;
  localparam logic MODE_COUNT = 1'b1;

  // Positions of the five totals inside one totals memory word.
  localparam int unsigned F_P3E = 0;
  localparam int unsigned F_P3M = 1;
  localparam int unsigned F_P4E = 2;
  localparam int unsigned F_P4I = 3;
  localparam int unsigned F_CY  = 4;

  // Which node of the current a->b->c walk receives its deferred update.
  typedef enum logic [1:0] {
    UPD_A = 2'd0,
    UPD_B = 2'd1,
    UPD_C = 2'd2
  } upd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     latch_edge;
    logic     edge_rd;
    logic     edge_wr;
    logic     a_init;
    logic     a_rd;
    logic     a_ld;
    logic     a_next;
    logic     b_pick;
    logic     b_ld;
    logic     c_pick;
    logic     c_ld;
    logic     d_pick;
    logic     d_wr;
    logic     upd_rd;
    logic     upd_wr;
    upd_sel_e upd_sel;
    logic     o_init;
    logic     o_rd;
    logic     o_ld;
    logic     o_next;
    logic     clear;
  } pnpcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ma_empty;
    logic mb_empty;
    logic md_empty;
    logic a_last;
    logic o_last;
  } pnpcc_sts_t;

  // Index of the lowest set bit, found by halving the window six times.
  function automatic logic [5:0] low_bit(input logic [SEARCH_W-1:0] x);
    logic [SEARCH_W-1:0] v;
    logic [5:0]          r;
    v = x;
    r = '0;
    if (v[31:0] == 32'h0) begin
      r[5] = 1'b1;
      v    = v >> 32;
    end
    if (v[15:0] == 16'h0) begin
      r[4] = 1'b1;
      v    = v >> 16;
    end
    if (v[7:0] == 8'h0) begin
      r[3] = 1'b1;
      v    = v >> 8;
    end
    if (v[3:0] == 4'h0) begin
      r[2] = 1'b1;
      v    = v >> 4;
    end
    if (v[1:0] == 2'h0) begin
      r[1] = 1'b1;
      v    = v >> 2;
    end
    if (v[0] == 1'b0) begin
      r[0] = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/pnpcc_ctrl.sv
// ============================================================================
// pnpcc_ctrl
// Controller state machine: sequences edge loading, the nested walk over
// a->b->c->d node sequences, the per-node result requests and the clear.
// ============================================================================
module pnpcc_ctrl
  import pnpcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  logic       s_mode_i,
  output logic       s_ready_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  input  pnpcc_sts_t sts_i,
  output pnpcc_cmd_t cmd_o
);

  typedef enum logic [17:0] {
    ST_IDLE    = 18'h00001,
    ST_EDGE_RD = 18'h00002,
    ST_EDGE_WR = 18'h00004,
    ST_A_RD    = 18'h00008,
    ST_A_LD    = 18'h00010,
    ST_B_PICK  = 18'h00020,
    ST_B_LD    = 18'h00040,
    ST_C_PICK  = 18'h00080,
    ST_C_LD    = 18'h00100,
    ST_D_PICK  = 18'h00200,
    ST_D_WR    = 18'h00400,
    ST_UPD_RD  = 18'h00800,
    ST_UPD_WR  = 18'h01000,
    ST_A_NEXT  = 18'h02000,
    ST_O_RD    = 18'h04000,
    ST_O_LD    = 18'h08000,
    ST_O_WAIT  = 18'h10000,
    ST_CLEAR   = 18'h20000
  } state_e;

  state_e   state_q, state_d;
  upd_sel_e upd_sel_q, upd_sel_d;

  // State and update selector registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      upd_sel_q <= UPD_A;
    end else begin
      state_q   <= state_d;
      upd_sel_q <= upd_sel_d;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d       = state_q;
    upd_sel_d     = upd_sel_q;
    cmd_o         = '0;
    cmd_o.upd_sel = upd_sel_q;
    s_ready_o     = 1'b0;
    m_valid_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.latch_edge = 1'b1;
          if (s_mode_i == MODE_COUNT) begin
            cmd_o.a_init = 1'b1;
            state_d      = ST_A_RD;
          end else begin
            state_d = ST_EDGE_RD;
          end
        end
      end
      ST_EDGE_RD: begin
        cmd_o.edge_rd = 1'b1;
        state_d       = ST_EDGE_WR;
      end
      ST_EDGE_WR: begin
        cmd_o.edge_wr = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_A_RD: begin
        cmd_o.a_rd = 1'b1;
        state_d    = ST_A_LD;
      end
      ST_A_LD: begin
        cmd_o.a_ld = 1'b1;
        state_d    = ST_B_PICK;
      end
      ST_B_PICK: begin
        if (sts_i.ma_empty) begin
          state_d = ST_A_NEXT;
        end else begin
          cmd_o.b_pick = 1'b1;
          state_d      = ST_B_LD;
        end
      end
      ST_B_LD: begin
        cmd_o.b_ld = 1'b1;
        state_d    = ST_C_PICK;
      end
      ST_C_PICK: begin
        if (sts_i.mb_empty) begin
          state_d = ST_B_PICK;
        end else begin
          cmd_o.c_pick = 1'b1;
          state_d      = ST_C_LD;
        end
      end
      ST_C_LD: begin
        cmd_o.c_ld = 1'b1;
        state_d    = ST_D_PICK;
      end
      ST_D_PICK: begin
        if (sts_i.md_empty) begin
          upd_sel_d = UPD_A;
          state_d   = ST_UPD_RD;
        end else begin
          cmd_o.d_pick = 1'b1;
          state_d      = ST_D_WR;
        end
      end
      ST_D_WR: begin
        cmd_o.d_wr = 1'b1;
        state_d    = ST_D_PICK;
      end
      ST_UPD_RD: begin
        cmd_o.upd_rd = 1'b1;
        state_d      = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd_o.upd_wr = 1'b1;
        case (upd_sel_q)
          UPD_A: begin
            upd_sel_d = UPD_B;
            state_d   = ST_UPD_RD;
          end
          UPD_B: begin
            upd_sel_d = UPD_C;
            state_d   = ST_UPD_RD;
          end
          default: begin
            state_d = ST_C_PICK;
          end
        endcase
      end
      ST_A_NEXT: begin
        if (sts_i.a_last) begin
          cmd_o.o_init = 1'b1;
          state_d      = ST_O_RD;
        end else begin
          cmd_o.a_next = 1'b1;
          state_d      = ST_A_RD;
        end
      end
      ST_O_RD: begin
        cmd_o.o_rd = 1'b1;
        state_d    = ST_O_LD;
      end
      ST_O_LD: begin
        cmd_o.o_ld = 1'b1;
        state_d    = ST_O_WAIT;
      end
      ST_O_WAIT: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          if (sts_i.o_last) begin
            state_d = ST_CLEAR;
          end else begin
            cmd_o.o_next = 1'b1;
            state_d      = ST_O_RD;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/pnpcc_dp.sv
// ============================================================================
// pnpcc_dp
// Datapath: configuration registers, adjacency row and column memories,
// walk masks and indexes, the totals memory with saturating updates, and
// the result register.
// ============================================================================
module pnpcc_dp
  import pnpcc_pkg::*;
#(
  parameter int unsigned MAX_NODES   = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic [5:0]  edge_from_i,
  input  logic [5:0]  edge_to_i,
  input  pnpcc_cmd_t  cmd_i,
  output pnpcc_sts_t  sts_o,
  output logic [5:0]  node_index_o,
  output logic [31:0] path3_end_count_o,
  output logic [31:0] path3_middle_count_o,
  output logic [31:0] path4_end_count_o,
  output logic [31:0] path4_inner_count_o,
  output logic [31:0] cycle4_count_o,
  output logic        last_node_o
);

  localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned KW = $clog2(MAX_NODES + 1);
  localparam int unsigned CW = COUNT_WIDTH;
  localparam logic [6:0]  MaxN = 7'(MAX_NODES);

  typedef logic [4:0][CW-1:0] tot_word_t;
  typedef logic [MAX_NODES-1:0] row_t;

  // Configuration registers.
  logic [6:0] node_total_q;
  logic       sym_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_total_q <= 7'd64;
      sym_q        <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_NODE_TOTAL) begin
        node_total_q <= cfg_wdata_i;
      end else begin
        sym_q <= cfg_wdata_i[0];
      end
    end
  end

  // Clamped node count, last index and mask of nodes in use.
  logic [6:0]    n_eff;
  logic [NW-1:0] last_idx;
  row_t          used;

  always_comb begin
    if (node_total_q == 7'd0) begin
      n_eff = 7'd1;
    end else if (node_total_q > MaxN) begin
      n_eff = MaxN;
    end else begin
      n_eff = node_total_q;
    end
    last_idx = NW'(n_eff - 7'd1);
    for (int j = 0; j < MAX_NODES; j++) begin
      used[j] = (7'(j) < n_eff);
    end
  end

  // Latched edge request.
  logic [5:0] from_q, to_q;
  logic       edge_ok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_edge) begin
      from_q    <= edge_from_i;
      to_q      <= edge_to_i;
      edge_ok_q <= ({1'b0, edge_from_i} < MaxN) && ({1'b0, edge_to_i} < MaxN)
                   && (edge_from_i != edge_to_i);
    end
  end

  // Walk indexes, masks and deferred counts.
  logic [NW-1:0] a_q, b_q, c_q, d_q, i_q;
  row_t          ma_q, mb_q, md_q, into_q;
  logic [KW-1:0] p4_q, cy_q;
  logic [NW-1:0] lo_ma, lo_mb, lo_md;

  assign lo_ma = NW'(low_bit(SEARCH_W'(ma_q)));
  assign lo_mb = NW'(low_bit(SEARCH_W'(mb_q)));
  assign lo_md = NW'(low_bit(SEARCH_W'(md_q)));

  function automatic row_t one_hot(input logic [NW-1:0] idx);
    return row_t'(1) << idx;
  endfunction

  // Adjacency memories: rows by source, columns by destination.
  row_t          row_mem [MAX_NODES];
  row_t          col_mem [MAX_NODES];
  row_t          row_vld_q, col_vld_q;
  row_t          row_rd_q, col_rd_q;
  logic          row_rv_q, col_rv_q;
  logic [NW-1:0] row_ra, col_ra;
  row_t          row_eff, col_eff;

  always_comb begin
    if (cmd_i.edge_rd) begin
      row_ra = from_q[NW-1:0];
    end else if (cmd_i.b_pick) begin
      row_ra = lo_ma;
    end else if (cmd_i.c_pick) begin
      row_ra = lo_mb;
    end else begin
      row_ra = a_q;
    end
    col_ra = cmd_i.edge_rd ? to_q[NW-1:0] : a_q;
  end

  assign row_eff = row_rv_q ? row_rd_q : '0;
  assign col_eff = col_rv_q ? col_rd_q : '0;

  // Registered reads and edge writes of the adjacency memories.
  always_ff @(posedge clk_i) begin
    row_rd_q <= row_mem[row_ra];
    col_rd_q <= col_mem[col_ra];
    if (cmd_i.edge_wr && edge_ok_q) begin
      row_mem[from_q[NW-1:0]] <= row_eff | one_hot(to_q[NW-1:0]);
      col_mem[to_q[NW-1:0]]   <= col_eff | one_hot(from_q[NW-1:0]);
    end
  end

  // Adjacency valid bits; the clear step empties the whole matrix.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      col_vld_q <= '0;
      row_rv_q  <= 1'b0;
      col_rv_q  <= 1'b0;
    end else begin
      row_rv_q <= row_vld_q[row_ra];
      col_rv_q <= col_vld_q[col_ra];
      if (cmd_i.clear) begin
        row_vld_q <= '0;
        col_vld_q <= '0;
      end else if (cmd_i.edge_wr && edge_ok_q) begin
        row_vld_q[from_q[NW-1:0]] <= 1'b1;
        col_vld_q[to_q[NW-1:0]]   <= 1'b1;
      end
    end
  end

  // Walk registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.a_init) begin
      a_q <= '0;
    end else if (cmd_i.a_next) begin
      a_q <= a_q + NW'(1);
    end
    if (cmd_i.a_ld) begin
      ma_q   <= row_eff & used & ~one_hot(a_q);
      into_q <= col_eff & used;
    end else if (cmd_i.b_pick) begin
      ma_q <= ma_q & ~one_hot(lo_ma);
    end
    if (cmd_i.b_pick) begin
      b_q <= lo_ma;
    end
    if (cmd_i.b_ld) begin
      mb_q <= row_eff & used & ~one_hot(a_q) & ~one_hot(b_q);
    end else if (cmd_i.c_pick) begin
      mb_q <= mb_q & ~one_hot(lo_mb);
    end
    if (cmd_i.c_pick) begin
      c_q <= lo_mb;
    end
    if (cmd_i.c_ld) begin
      md_q <= row_eff & used & ~one_hot(a_q) & ~one_hot(b_q) & ~one_hot(c_q);
      p4_q <= '0;
      cy_q <= '0;
    end else if (cmd_i.d_pick) begin
      md_q <= md_q & ~one_hot(lo_md);
      p4_q <= p4_q + KW'(1);
      cy_q <= cy_q + KW'(into_q[lo_md]);
    end
    if (cmd_i.d_pick) begin
      d_q <= lo_md;
    end
    if (cmd_i.o_init) begin
      i_q <= '0;
    end else if (cmd_i.o_next) begin
      i_q <= i_q + NW'(1);
    end
  end

  assign sts_o.ma_empty = (ma_q == '0);
  assign sts_o.mb_empty = (mb_q == '0);
  assign sts_o.md_empty = (md_q == '0);
  assign sts_o.a_last   = (a_q == last_idx);
  assign sts_o.o_last   = (i_q == last_idx);

  // Totals memory with per-entry valid bits.
  tot_word_t         tot_mem [MAX_NODES];
  logic [MAX_NODES-1:0] tot_vld_q;
  tot_word_t         tot_rd_q, tot_eff, tot_new;
  logic              tot_rv_q;
  logic [NW-1:0]     upd_node, tot_ra, tot_wa;
  logic [4:0][KW-1:0] inc;
  logic              tot_we;

  always_comb begin
    case (cmd_i.upd_sel)
      UPD_A:   upd_node = a_q;
      UPD_B:   upd_node = b_q;
      default: upd_node = c_q;
    endcase
    if (cmd_i.d_pick) begin
      tot_ra = lo_md;
    end else if (cmd_i.upd_rd) begin
      tot_ra = upd_node;
    end else begin
      tot_ra = i_q;
    end
    tot_wa = cmd_i.d_wr ? d_q : upd_node;
    tot_we = cmd_i.d_wr || cmd_i.upd_wr;
  end

  assign tot_eff = tot_rv_q ? tot_rd_q : '0;

  // Increments: a found d gets one 4-path end and maybe a cycle; a, b and c
  // take their 3-path count and the deferred 4-path and cycle counts.
  always_comb begin
    inc = '0;
    if (cmd_i.d_wr) begin
      inc[F_P4E] = KW'(1);
      inc[F_CY]  = KW'(into_q[d_q]);
    end else begin
      inc[F_CY] = cy_q;
      case (cmd_i.upd_sel)
        UPD_A: begin
          inc[F_P3E] = KW'(1);
          inc[F_P4E] = p4_q;
        end
        UPD_B: begin
          inc[F_P3M] = KW'(1);
          inc[F_P4I] = p4_q;
        end
        default: begin
          inc[F_P3E] = KW'(1);
          inc[F_P4I] = p4_q;
        end
      endcase
    end
  end

  // Saturating add of the five fields.
  always_comb begin
    logic [CW:0] sum;
    for (int f = 0; f < 5; f++) begin
      sum        = {1'b0, tot_eff[f]} + (CW+1)'(inc[f]);
      tot_new[f] = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    tot_rd_q <= tot_mem[tot_ra];
    if (tot_we) begin
      tot_mem[tot_wa] <= tot_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_vld_q <= '0;
      tot_rv_q  <= 1'b0;
    end else begin
      tot_rv_q <= tot_vld_q[tot_ra];
      if (cmd_i.clear) begin
        tot_vld_q <= '0;
      end else if (tot_we) begin
        tot_vld_q[tot_wa] <= 1'b1;
      end
    end
  end

  // Result register: totals (halved in symmetric mode, the cycle total always scaled), low 32 bits of each.
  function automatic logic [31:0] low32(input logic [CW-1:0] v);
    logic [CW+31:0] ext;
    ext = {32'h0, v};
    return ext[31:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.o_ld) begin
      node_index_o <= 6'(i_q);
      last_node_o  <= sts_o.o_last;
      if (sym_q) begin
        path3_end_count_o    <= low32(tot_eff[F_P3E] >> 1);
        path3_middle_count_o <= low32(tot_eff[F_P3M] >> 1);
        path4_end_count_o    <= low32(tot_eff[F_P4E] >> 1);
        path4_inner_count_o  <= low32(tot_eff[F_P4I] >> 1);
        cycle4_count_o       <= low32(tot_eff[F_CY] >> 3);
      end else begin
        path3_end_count_o    <= low32(tot_eff[F_P3E]);
        path3_middle_count_o <= low32(tot_eff[F_P3M]);
        path4_end_count_o    <= low32(tot_eff[F_P4E]);
        path4_inner_count_o  <= low32(tot_eff[F_P4I]);
        cycle4_count_o       <= low32(tot_eff[F_CY] >> 2);
      end
    end
  end

endmodule

FILE: rtl/per_node_path_cycle_counter.sv
// ============================================================================
// per_node_path_cycle_counter
// Loads directed edges into an adjacency matrix, then on a count request
// walks every a->b->c->d sequence of distinct nodes and returns per-node
// 3-path, 4-path and four-node loop totals, one result per node in use.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser: mode; tdata: edge_from, edge_to
//   m_axis    out        tdata: node_index and five counts; tlast: last_node
//   cfg       in         write of node_total (0) or symmetric_mode (1)
//
// An edge request is accepted, its row and column are read, then written back.
// A count request visits each node a, each b and each c, writes each d
// found and then makes the deferred a/b/c updates, all paced by the single
// read/modify/write port of the totals memory; then it delivers each result,
// waiting on any output stall, and finally clears matrix and totals.
// Reset clears all valid bits at once, so no clearing pass follows it.
// No new request is taken until the last result of a count is delivered.
// ============================================================================
module per_node_path_cycle_counter
  import pnpcc_pkg::*;
#(
  parameter int unsigned MAX_NODES   = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_addr_i,
  input  logic [6:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // edge_from[5:0], edge_to[11:6]
  input  logic         s_axis_tuser,   // mode[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata,   // node_index, path3_end, path3_middle,
                                       // path4_end, path4_inner, cycle4
  output logic         m_axis_tlast    // last_node
);

  pnpcc_cmd_t  cmd;
  pnpcc_sts_t  sts;
  logic [5:0]  node_index;
  logic [31:0] p3e, p3m, p4e, p4i, cy4;

  pnpcc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_mode_i  (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pnpcc_dp #(
    .MAX_NODES   (MAX_NODES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_addr_i           (cfg_addr_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .edge_from_i          (s_axis_tdata[5:0]),
    .edge_to_i            (s_axis_tdata[11:6]),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .node_index_o         (node_index),
    .path3_end_count_o    (p3e),
    .path3_middle_count_o (p3m),
    .path4_end_count_o    (p4e),
    .path4_inner_count_o  (p4i),
    .cycle4_count_o       (cy4),
    .last_node_o          (m_axis_tlast)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {2'b00, cy4, p4i, p4e, p3m, p3e, node_index};

endmodule

FILE: rtl/pnpcc_checker.sv
// ============================================================================
// pnpcc_checker
// Port-level checks of the per-node path and cycle counter, bound to the
// top level.
// ============================================================================
module pnpcc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [167:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // No request is taken while a result is on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request taken during result delivery");

  // The last result of a count is not directly followed by another result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("result after last node");

  // A count request closes the input and offers no result as the walk starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=>
      !s_axis_tready && !m_axis_tvalid)
    else $error("input open right after count request");

endmodule

bind per_node_path_cycle_counter pnpcc_checker u_pnpcc_checker (.*);
